>>> rtl/core/battery_voltage_moving_average_assert.svh
// ----------------------------------------------------------------------------
// Battery voltage moving average assertion macros
// Shared concurrent assertion forms for the block's checker.
// ----------------------------------------------------------------------------
`ifndef BATTERY_VOLTAGE_MOVING_AVERAGE_ASSERT_SVH
`define BATTERY_VOLTAGE_MOVING_AVERAGE_ASSERT_SVH

// Checked at every edge, reset disables the check.
`define BVMA_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define BVMA_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/bvma_pkg.sv
// ----------------------------------------------------------------------------
// Battery voltage moving average package
// Field widths, scaling constants and shared types.
// ----------------------------------------------------------------------------
package bvma_pkg;

	localparam int unsigned SAMPLE_W        = 10;
	localparam int unsigned TENTHS_W        = 7;
	localparam int unsigned WINDOW_LOG2_DEF = 5;

	localparam int unsigned RESET_ENTRY = 96;
	localparam int unsigned TENTHS_MAX  = 101;

	// Pin voltage stage: (x * 330 + 511) / 1023.
	localparam int unsigned PIN_SCALE = 330;
	localparam int unsigned PIN_ROUND = 511;
	localparam int unsigned PIN_DIV   = 1023;
	localparam int unsigned PIN_SHIFT = 10;
	localparam int unsigned PIN_N_W   = 19;
	localparam int unsigned PIN_W     = PIN_N_W - PIN_SHIFT;

	// Divider stage: (p * 10100 + 1650) / 33000.
	localparam int unsigned DIV_SCALE   = 3300 + 6800;
	localparam int unsigned DIV_ROUND   = 1650;
	localparam int unsigned DIV_DIV     = 33000;
	localparam int unsigned RECIP_SHIFT = 32;
	localparam int unsigned RECIP_W     = 17;
	localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / DIV_DIV);
	localparam int unsigned M_W    = 22;
	localparam int unsigned PROD_W = M_W + RECIP_W;

	typedef struct packed {
		logic rd;
		logic commit;
	} ring_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCALE = 3'b010,
		ST_HOLD  = 3'b100
	} state_t;

endpackage

>>> rtl/core/bvma_scale.sv
// ----------------------------------------------------------------------------
// Battery voltage scaling pipeline
// Four registered stages turn a raw reading into tenths of a volt.
// ----------------------------------------------------------------------------
module bvma_scale (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [bvma_pkg::SAMPLE_W-1:0]  sample,
	output logic                           done,
	output logic [bvma_pkg::TENTHS_W-1:0]  tenths
);
	import bvma_pkg::*;

	logic               v_s1, v_s2, v_s3, v_s4;
	logic [PIN_N_W-1:0] n_s1;
	logic [M_W-1:0]     m_s2, m_s3;
	logic [TENTHS_W-1:0] q_s3, t_s4;

	logic [PIN_W-1:0]  pin_est;
	logic [PIN_SHIFT:0] pin_rem;
	logic [PIN_W-1:0]  pin;
	logic [M_W-1:0]    m_next;
	logic [PROD_W-1:0] prod;
	logic [M_W-1:0]    rem;
	logic [TENTHS_W-1:0] t_next;

	// Division by 1023 starts from a shift by 1024, which is low by at most one.
	always_comb begin
		pin_est = n_s1[PIN_N_W-1:PIN_SHIFT];
		pin_rem = (PIN_SHIFT+1)'(n_s1[PIN_SHIFT-1:0]) + (PIN_SHIFT+1)'(pin_est);
		pin     = pin_est + PIN_W'(pin_rem >= (PIN_SHIFT+1)'(PIN_DIV));
		m_next  = M_W'(pin) * M_W'(DIV_SCALE) + M_W'(DIV_ROUND);
	end

	// Division by 33000 uses a truncated reciprocal and one correction step.
	assign prod = PROD_W'(m_s2) * PROD_W'(DIV_RECIP);

	always_comb begin
		rem    = m_s3 - M_W'(q_s3) * M_W'(DIV_DIV);
		t_next = q_s3 + TENTHS_W'(rem >= M_W'(DIV_DIV));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_s1 <= PIN_N_W'(sample) * PIN_N_W'(PIN_SCALE) + PIN_N_W'(PIN_ROUND);
		end
		if (v_s1) begin
			m_s2 <= m_next;
		end
		if (v_s2) begin
			q_s3 <= prod[RECIP_SHIFT +: TENTHS_W];
			m_s3 <= m_s2;
		end
		if (v_s3) begin
			t_s4 <= t_next;
		end
	end

	assign done   = v_s4;
	assign tenths = t_s4;

endmodule

>>> rtl/core/bvma_ring.sv
// ----------------------------------------------------------------------------
// Battery voltage sample ring
// Sample memory with running sum, write index and per-entry valid bits.
// ----------------------------------------------------------------------------
module bvma_ring #(
	parameter int unsigned WINDOW_LOG2 = bvma_pkg::WINDOW_LOG2_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bvma_pkg::ring_ctrl_t          ctrl,
	input  logic [bvma_pkg::TENTHS_W-1:0] tenths,
	output logic [bvma_pkg::TENTHS_W-1:0] mean
);
	import bvma_pkg::*;

	localparam int unsigned DEPTH = 1 << WINDOW_LOG2;
	localparam int unsigned SUM_W = TENTHS_W + WINDOW_LOG2;

	logic [TENTHS_W-1:0]    mem [DEPTH];
	logic [DEPTH-1:0]       valid_q;
	logic [WINDOW_LOG2-1:0] idx_q;
	logic [SUM_W-1:0]       sum_q;
	logic [TENTHS_W-1:0]    rd_data_q;
	logic                   rd_valid_q;
	logic [TENTHS_W-1:0]    old_entry;
	logic [SUM_W-1:0]       sum_next;

	// An entry that was never written still holds its reset value.
	assign old_entry = rd_valid_q ? rd_data_q : TENTHS_W'(RESET_ENTRY);
	assign sum_next  = sum_q - SUM_W'(old_entry) + SUM_W'(tenths);
	assign mean      = sum_next[SUM_W-1 -: TENTHS_W];

	always_ff @(posedge clk) begin
		if (ctrl.commit) begin
			mem[idx_q] <= tenths;
		end
		if (ctrl.rd) begin
			rd_data_q <= mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			idx_q      <= '0;
			sum_q      <= SUM_W'(RESET_ENTRY) << WINDOW_LOG2;
			rd_valid_q <= 1'b0;
		end else begin
			if (ctrl.rd) begin
				rd_valid_q <= valid_q[idx_q];
			end
			if (ctrl.commit) begin
				valid_q[idx_q] <= 1'b1;
				idx_q          <= idx_q + 1'b1;
				sum_q          <= sum_next;
			end
		end
	end

endmodule

>>> rtl/core/battery_voltage_moving_average.sv
// ----------------------------------------------------------------------------
// Battery voltage moving average
// Scales raw battery readings to tenths of a volt and averages the last
// 2^WINDOW_LOG2 of them.
// ----------------------------------------------------------------------------
// One sample is handled at a time: it passes through the scaling pipeline
// (pin voltage, divider product, reciprocal multiply, correction), and then,
// in the cycle in which scaling ends if the output register is free, the
// ring entry, the running sum and the write index are updated and the mean
// is loaded into the output register. The ring's old entry is read from the
// sample memory into a register as the sample is accepted and scaling starts.
// The output register lets the next sample enter while a mean still waits;
// if it is still occupied when scaling ends, the update waits for it. After
// reset every ring entry reads as 96 (9.6 V) through per-entry valid bits, so
// the block accepts samples at once with no clearing pass.
// ----------------------------------------------------------------------------
module battery_voltage_moving_average #(
	parameter int unsigned WINDOW_LOG2 = bvma_pkg::WINDOW_LOG2_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [bvma_pkg::SAMPLE_W-1:0] adc_sample,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [bvma_pkg::TENTHS_W-1:0] battery_tenths_volt
);
	import bvma_pkg::*;

	state_t              state_q, state_next;
	ring_ctrl_t          ring_ctrl;
	logic                scale_done;
	logic [TENTHS_W-1:0] tenths;
	logic [TENTHS_W-1:0] mean;
	logic                out_free;
	logic                out_valid_q;
	logic [TENTHS_W-1:0] out_q;

	bvma_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ring_ctrl.rd),
		.sample (adc_sample),
		.done   (scale_done),
		.tenths (tenths)
	);

	bvma_ring #(
		.WINDOW_LOG2 (WINDOW_LOG2)
	) u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ring_ctrl),
		.tenths (tenths),
		.mean   (mean)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		ring_ctrl.rd     = in_valid && in_ready;
		ring_ctrl.commit = 1'b0;
		state_next       = state_q;
		case (state_q)
			ST_IDLE: begin
				if (ring_ctrl.rd) begin
					state_next = ST_SCALE;
				end
			end
			ST_SCALE: begin
				if (scale_done) begin
					ring_ctrl.commit = out_free;
					state_next       = out_free ? ST_IDLE : ST_HOLD;
				end
			end
			ST_HOLD: begin
				ring_ctrl.commit = out_free;
				if (out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (ring_ctrl.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ring_ctrl.commit) begin
			out_q <= mean;
		end
	end

	assign out_valid           = out_valid_q;
	assign battery_tenths_volt = out_q;

endmodule

>>> rtl/core/bvma_checker.sv
// ----------------------------------------------------------------------------
// Battery voltage moving average checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "battery_voltage_moving_average_assert.svh"

module bvma_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic [bvma_pkg::SAMPLE_W-1:0] adc_sample,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [bvma_pkg::TENTHS_W-1:0] battery_tenths_volt
);
	import bvma_pkg::*;

	logic                in_xfer;
	logic                in_stall;
	logic                out_stall;
	logic                mean_ok;
	logic [SAMPLE_W:0]   in_word;
	logic [TENTHS_W:0]   out_word;

	assign in_xfer   = in_valid && in_ready;
	assign in_stall  = in_valid && !in_ready;
	assign out_stall = out_valid && !out_ready;
	assign mean_ok   = battery_tenths_volt <= TENTHS_W'(TENTHS_MAX);
	assign in_word   = {in_valid, adc_sample};
	assign out_word  = {out_valid, battery_tenths_volt};

	// A mean can never exceed the largest scaled reading.
	`BVMA_ASSERT_ALWAYS(a_mean_range, clk, !out_valid || mean_ok, "mean above 10.1 V")

	// Only one sample is in flight, so a transaction closes the input side.
	`BVMA_ASSERT(a_one_in_flight, clk, arst_n, in_xfer |=> !in_ready, "input taken while busy")

	// A new result only appears while a sample is being worked on.
	`BVMA_ASSERT(a_result_source, clk, arst_n, $rose(out_valid) |-> !$past(in_ready), "orphan result")

	`BVMA_ASSERT(a_in_hold, clk, arst_n, in_stall |=> $stable(in_word), "stalled input changed")

	`BVMA_ASSERT(a_out_hold, clk, arst_n, out_stall |=> $stable(out_word), "stalled result changed")

endmodule

bind battery_voltage_moving_average bvma_checker u_checker (.*);
